FILE: rtl/core/stftpsd_pkg.sv
package stftpsd_pkg;

    typedef longint unsigned u64_t;

    localparam int NPERSEG = 64;
    localparam int NBINS   = NPERSEG / 2 + 1;
    localparam int IDX_W   = $clog2(NPERSEG);
    localparam int SMP_W   = 14;
    localparam int WIN_W   = 16;
    localparam int TW_W    = 17;
    localparam int SCR_W   = 29;
    localparam int PROD_W  = SCR_W + TW_W;
    localparam int ACC_W   = PROD_W + IDX_W;
    localparam int SH_W    = $clog2(ACC_W - 31 + 1);
    localparam int FNUM_W  = 16;
    localparam int BIN_W   = 6;
    localparam int DB_W    = 16;
    localparam int OVL_W   = 6;
    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_PTR_W = 1;

    localparam logic [OVL_W-1:0]       OVERLAP_RESET = 6'd32;
    localparam logic signed [DB_W-1:0] DB_MIN        = -16'sd30720;
    localparam logic signed [DB_W-1:0] DB_MAX        = 16'sd4096;
    localparam logic signed [25:0]     DB_K_Q16      = 26'sd25252226;
    localparam logic signed [7:0]      LOG_BIAS      = 8'sd86;
    localparam logic [5:0]             SQ_TOP        = 6'd62;

    localparam u64_t Q30_ONE     = 64'd1073741824;
    localparam u64_t HALF_PI_Q30 = 64'd1686629713;
    localparam u64_t HANN_DEN    = u64_t'(NPERSEG - 1);
    localparam u64_t SIN_DEN     = u64_t'(4 * NPERSEG);

    typedef u64_t div_arr_t [8];
    localparam div_arr_t COS_DIV = '{64'd1, 64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132,
                                     64'd182};
    localparam div_arr_t SIN_DIV = '{64'd1, 64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156,
                                     64'd210};

    typedef struct packed {
        logic signed [SMP_W-1:0] sample;
        logic                    block_start;
    } smp_in_t;

    typedef struct packed {
        logic [FNUM_W-1:0]      frame_number;
        logic [BIN_W-1:0]       bin;
        logic signed [DB_W-1:0] level_db;
        logic                   last_bin;
    } res_t;

    typedef struct packed {
        logic signed [SMP_W-1:0] sample;
        logic                    frame;
        logic [FNUM_W-1:0]       fnum;
    } cmd_t;

    typedef enum logic [3:0] {
        B_IDLE,
        B_WIN,
        B_DFT,
        B_DRAIN,
        B_ABS,
        B_SHIFT,
        B_SQ,
        B_SUM,
        B_NORM,
        B_LOG,
        B_MULK,
        B_ROUND,
        B_OUT
    } bk_state_t;

    typedef logic [WIN_W-1:0]       win_arr_t [NPERSEG];
    typedef logic signed [TW_W-1:0] tw_arr_t [NPERSEG];

    // Q30 Taylor series on a quarter turn
    function automatic longint series(input u64_t x, input logic want_sin);
        u64_t   x2;
        u64_t   term;
        longint acc;
        x2   = (x * x) >> 30;
        term = want_sin ? x : Q30_ONE;
        acc  = longint'(term);
        for (int k = 1; k <= 7; k++)
        begin
            if (want_sin)
                term = ((term * x2) >> 30) / SIN_DIV[k];
            else
                term = ((term * x2) >> 30) / COS_DIV[k];
            if ((k & 1) == 1)
                acc = acc - longint'(term);
            else
                acc = acc + longint'(term);
        end
        return acc;
    endfunction

    // Q30 cosine of a 32-bit phase fraction of a turn
    function automatic longint cos_phase(input u64_t ph);
        u64_t   quad;
        u64_t   f;
        u64_t   x;
        longint r;
        quad = (ph >> 30) & 64'd3;
        f    = ph & (Q30_ONE - 64'd1);
        x    = (f * HALF_PI_Q30) >> 30;
        if (quad == 64'd0)
            r = series(x, 1'b0);
        else if (quad == 64'd1)
            r = -series(x, 1'b1);
        else if (quad == 64'd2)
            r = -series(x, 1'b0);
        else
            r = series(x, 1'b1);
        if (r > longint'(Q30_ONE))
            r = longint'(Q30_ONE);
        if (r < -longint'(Q30_ONE))
            r = -longint'(Q30_ONE);
        return r;
    endfunction

    function automatic logic signed [TW_W-1:0] to_q15(input longint c30);
        u64_t   u;
        longint v;
        u = u64_t'(c30 + longint'(Q30_ONE)) + 64'd16384;
        v = longint'(u >> 15) - 64'sd32768;
        return TW_W'(v);
    endfunction

    function automatic win_arr_t build_hann();
        win_arr_t t;
        u64_t     ph;
        u64_t     w;
        longint   c;
        for (int i = 0; i < NPERSEG; i++)
        begin
            ph = ((u64_t'(i) % HANN_DEN) << 32) / HANN_DEN;
            c  = cos_phase(ph);
            w  = u64_t'(longint'(Q30_ONE) - c) >> 16;
            t[i] = (w > 64'd32767) ? WIN_W'(32767) : WIN_W'(w);
        end
        return t;
    endfunction

    function automatic tw_arr_t build_cos();
        tw_arr_t t;
        u64_t    ph;
        for (int i = 0; i < NPERSEG; i++)
        begin
            ph   = (u64_t'(i) << 32) / NPERSEG;
            t[i] = to_q15(cos_phase(ph));
        end
        return t;
    endfunction

    function automatic tw_arr_t build_sin();
        tw_arr_t t;
        u64_t    ph;
        for (int i = 0; i < NPERSEG; i++)
        begin
            ph   = ((u64_t'(4 * i + 3 * NPERSEG) % SIN_DEN) << 32) / SIN_DEN;
            t[i] = to_q15(cos_phase(ph));
        end
        return t;
    endfunction

    localparam win_arr_t HANN_ROM = build_hann();
    localparam tw_arr_t  COS_TAB  = build_cos();
    localparam tw_arr_t  SIN_TAB  = build_sin();

endpackage

FILE: rtl/core/stftpsd_cmd_fifo.sv
module stftpsd_cmd_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr,
    input  stftpsd_pkg::cmd_t   wdata,
    output logic                full,
    input  logic                rd,
    output stftpsd_pkg::cmd_t   rdata,
    output logic                empty
);
    import stftpsd_pkg::*;

    cmd_t                  slot_reg [CMDQ_DEPTH];
    logic [CMDQ_PTR_W-1:0] wptr_reg;
    logic [CMDQ_PTR_W-1:0] rptr_reg;
    logic [CMDQ_PTR_W:0]   count_reg;
    logic [CMDQ_PTR_W:0]   count_next;
    logic                  do_wr;
    logic                  do_rd;

    assign full  = (count_reg == (CMDQ_PTR_W + 1)'(CMDQ_DEPTH));
    assign empty = (count_reg == '0);
    assign do_wr = wr && !full;
    assign do_rd = rd && !empty;
    assign rdata = slot_reg[rptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_wr && !do_rd)
            count_next = count_reg + 1'b1;
        else if (do_rd && !do_wr)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_wr)
                wptr_reg <= wptr_reg + 1'b1;
            if (do_rd)
                rptr_reg <= rptr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            slot_reg[wptr_reg] <= wdata;
    end

endmodule

FILE: rtl/core/stftpsd_front.sv
module stftpsd_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    output logic                                full,
    input  stftpsd_pkg::smp_in_t                item,
    input  logic                                overlap_we,
    input  logic [stftpsd_pkg::OVL_W-1:0]       overlap_data,
    output logic                                cmd_push,
    output stftpsd_pkg::cmd_t                   cmd,
    input  logic                                cmd_full
);
    import stftpsd_pkg::*;

    logic [OVL_W-1:0]  overlap_reg;
    logic [IDX_W:0]    seen_reg;
    logic [IDX_W:0]    seen_next;
    logic [IDX_W-1:0]  phase_reg;
    logic [IDX_W-1:0]  phase_next;
    logic [FNUM_W-1:0] fc_reg;
    logic [FNUM_W-1:0] fc_next;
    logic              accept;
    logic              frame;

    assign full     = cmd_full;
    assign accept   = push && !cmd_full;
    assign cmd_push = accept;

    always_comb
    begin
        logic [IDX_W:0]    seen_eff;
        logic [IDX_W-1:0]  phase_eff;
        logic [FNUM_W-1:0] fc_eff;
        logic [IDX_W:0]    hop;
        logic [IDX_W:0]    ph1;
        seen_eff  = item.block_start ? '0 : seen_reg;
        phase_eff = item.block_start ? '0 : phase_reg;
        fc_eff    = item.block_start ? '0 : fc_reg;
        hop       = (IDX_W + 1)'(NPERSEG) - (IDX_W + 1)'(overlap_reg);
        ph1       = {1'b0, phase_eff} + 1'b1;
        frame     = 1'b0;
        seen_next = seen_eff;
        phase_next = phase_eff;
        if (seen_eff < (IDX_W + 1)'(NPERSEG))
        begin
            seen_next = seen_eff + 1'b1;
            if (seen_next == (IDX_W + 1)'(NPERSEG))
            begin
                frame      = 1'b1;
                phase_next = '0;
            end
        end
        else if (ph1 >= hop)
        begin
            frame      = 1'b1;
            phase_next = '0;
        end
        else
        begin
            phase_next = ph1[IDX_W-1:0];
        end
        fc_next    = fc_eff + FNUM_W'(frame);
        cmd.sample = item.sample;
        cmd.frame  = frame;
        cmd.fnum   = fc_eff;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            overlap_reg <= OVERLAP_RESET;
            seen_reg    <= '0;
            phase_reg   <= '0;
            fc_reg      <= '0;
        end
        else
        begin
            if (overlap_we)
                overlap_reg <= overlap_data;
            if (accept)
            begin
                seen_reg  <= seen_next;
                phase_reg <= phase_next;
                fc_reg    <= fc_next;
            end
        end
    end

endmodule

FILE: rtl/core/stftpsd_back.sv
module stftpsd_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_empty,
    input  stftpsd_pkg::cmd_t   cmd,
    output logic                cmd_pop,
    output logic                empty,
    input  logic                pop,
    output stftpsd_pkg::res_t   result
);
    import stftpsd_pkg::*;

    bk_state_t state_reg;
    bk_state_t state_next;

    logic signed [SMP_W-1:0] hist_mem [NPERSEG];
    logic signed [SCR_W-1:0] scr_mem [NPERSEG];
    logic [NPERSEG-1:0]      hvalid_reg;
    logic [IDX_W-1:0]        wptr_reg;
    logic [IDX_W-1:0]        n_reg;
    logic [IDX_W-1:0]        j_reg;
    logic [IDX_W-1:0]        k_reg;
    logic [FNUM_W-1:0]       fnum_reg;

    logic signed [SMP_W-1:0] hrd_reg;
    logic                    hv_reg;
    logic [IDX_W-1:0]        wn_reg;
    logic                    wv_reg;

    logic signed [SCR_W-1:0]  srd_reg;
    logic [IDX_W-1:0]         j1_reg;
    logic                     v1_reg;
    logic signed [PROD_W-1:0] pre_reg;
    logic signed [PROD_W-1:0] pim_reg;
    logic                     v2_reg;
    logic signed [ACC_W-1:0]  acc_re_reg;
    logic signed [ACC_W-1:0]  acc_im_reg;

    logic [ACC_W-1:0]         a_reg;
    logic [ACC_W-1:0]         b_reg;
    logic [SH_W-1:0]          s_reg;
    logic [61:0]              a2_reg;
    logic [61:0]              b2_reg;
    logic [62:0]              m_reg;
    logic [5:0]               e_reg;
    logic [31:0]              ml_reg;
    logic [15:0]              frac_reg;
    logic [3:0]               it_reg;
    logic signed [49:0]       p_reg;
    logic signed [DB_W-1:0]   level_reg;
    res_t                     res_reg;
    logic                     res_valid_reg;

    logic                      n_last;
    logic                      k_last;
    logic                      win_issue;
    logic                      dft_issue;
    logic                      bin_start;
    logic                      res_load;
    logic                      shift_more;
    logic [62:0]               sq_sum;
    logic [IDX_W-1:0]          win_addr;
    logic signed [SMP_W-1:0]   hsmp;
    logic signed [SMP_W+WIN_W:0] wprod;
    logic [63:0]               ml_sq;
    logic [31:0]               ml_t;

    function automatic logic [IDX_W-1:0] idx_add(input logic [IDX_W-1:0] x,
                                                 input logic [IDX_W-1:0] y);
        logic [IDX_W:0] sum;
        sum = {1'b0, x} + {1'b0, y};
        if (sum >= (IDX_W + 1)'(NPERSEG))
            sum = sum - (IDX_W + 1)'(NPERSEG);
        return sum[IDX_W-1:0];
    endfunction

    assign n_last     = (n_reg == IDX_W'(NPERSEG - 1));
    assign k_last     = (k_reg == IDX_W'(NBINS - 1));
    assign shift_more = |(a_reg[ACC_W-1:31] | b_reg[ACC_W-1:31]);
    assign sq_sum     = {1'b0, a2_reg} + {1'b0, b2_reg};
    assign win_addr   = idx_add(wptr_reg, n_reg);
    assign hsmp       = hv_reg ? hrd_reg : '0;
    assign wprod      = hsmp * $signed({1'b0, HANN_ROM[wn_reg]});
    assign ml_sq      = ml_reg * ml_reg;
    assign ml_t       = ml_sq[61:30];
    assign empty      = !res_valid_reg;
    assign result     = res_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:
                if (!cmd_empty && cmd.frame)
                    state_next = B_WIN;
            B_WIN:
                if (n_last)
                    state_next = B_DFT;
            B_DFT:
                if (n_last)
                    state_next = B_DRAIN;
            B_DRAIN:
                if (!v1_reg && !v2_reg)
                    state_next = B_ABS;
            B_ABS:
                state_next = B_SHIFT;
            B_SHIFT:
                if (!shift_more)
                    state_next = B_SQ;
            B_SQ:
                state_next = B_SUM;
            B_SUM:
                state_next = (sq_sum == '0) ? B_OUT : B_NORM;
            B_NORM:
                if (m_reg[62])
                    state_next = B_LOG;
            B_LOG:
                if (it_reg == 4'd15)
                    state_next = B_MULK;
            B_MULK:
                state_next = B_ROUND;
            B_ROUND:
                state_next = B_OUT;
            B_OUT:
                if (!res_valid_reg || pop)
                    state_next = k_last ? B_IDLE : B_DFT;
            default:
                state_next = B_IDLE;
        endcase
    end

    always_comb
    begin
        cmd_pop   = (state_reg == B_IDLE) && !cmd_empty;
        win_issue = (state_reg == B_WIN);
        dft_issue = (state_reg == B_DFT);
        res_load  = (state_reg == B_OUT) && (!res_valid_reg || pop);
        bin_start = (win_issue && n_last) || (res_load && !k_last);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            hvalid_reg    <= '0;
            wptr_reg      <= '0;
            n_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            wv_reg        <= 1'b0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            wv_reg    <= win_issue;
            v1_reg    <= dft_issue;
            v2_reg    <= v1_reg;
            if (cmd_pop)
            begin
                hvalid_reg[wptr_reg] <= 1'b1;
                wptr_reg             <= idx_add(wptr_reg, IDX_W'(1));
                if (cmd.frame)
                    k_reg <= '0;
            end
            if (bin_start)
            begin
                n_reg <= '0;
                j_reg <= '0;
            end
            else if (win_issue || dft_issue)
            begin
                n_reg <= n_last ? '0 : n_reg + 1'b1;
                if (dft_issue)
                    j_reg <= idx_add(j_reg, k_reg);
            end
            if (res_load && !k_last)
                k_reg <= k_reg + 1'b1;
            if (res_load)
                res_valid_reg <= 1'b1;
            else if (pop)
                res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            hist_mem[wptr_reg] <= cmd.sample;
            if (cmd.frame)
                fnum_reg <= cmd.fnum;
        end

        // window pass: oldest sample first
        hrd_reg <= hist_mem[win_addr];
        hv_reg  <= hvalid_reg[win_addr];
        wn_reg  <= n_reg;
        if (wv_reg)
            scr_mem[wn_reg] <= wprod[SCR_W-1:0];

        // DFT multiply-accumulate
        srd_reg <= scr_mem[n_reg];
        j1_reg  <= j_reg;
        pre_reg <= srd_reg * COS_TAB[j1_reg];
        pim_reg <= srd_reg * SIN_TAB[j1_reg];
        if (bin_start)
        begin
            acc_re_reg <= '0;
            acc_im_reg <= '0;
        end
        else if (v2_reg)
        begin
            acc_re_reg <= acc_re_reg + ACC_W'(pre_reg);
            acc_im_reg <= acc_im_reg + ACC_W'(pim_reg);
        end

        case (state_reg)
            B_ABS:
            begin
                a_reg <= acc_re_reg[ACC_W-1] ? ACC_W'(-acc_re_reg) : ACC_W'(acc_re_reg);
                b_reg <= acc_im_reg[ACC_W-1] ? ACC_W'(-acc_im_reg) : ACC_W'(acc_im_reg);
                s_reg <= '0;
            end
            B_SHIFT:
                if (shift_more)
                begin
                    a_reg <= a_reg >> 1;
                    b_reg <= b_reg >> 1;
                    s_reg <= s_reg + 1'b1;
                end
            B_SQ:
            begin
                a2_reg <= a_reg[30:0] * a_reg[30:0];
                b2_reg <= b_reg[30:0] * b_reg[30:0];
            end
            B_SUM:
            begin
                m_reg     <= sq_sum;
                e_reg     <= SQ_TOP;
                level_reg <= DB_MIN;
            end
            B_NORM:
                if (m_reg[62])
                begin
                    ml_reg   <= {1'b0, m_reg[62:32]};
                    frac_reg <= '0;
                    it_reg   <= '0;
                end
                else
                begin
                    m_reg <= m_reg << 1;
                    e_reg <= e_reg - 1'b1;
                end
            B_LOG:
            begin
                // square, then drop one octave when the mantissa reaches two
                if (ml_t[31])
                begin
                    ml_reg   <= {1'b0, ml_t[31:1]};
                    frac_reg <= {frac_reg[14:0], 1'b1};
                end
                else
                begin
                    ml_reg   <= ml_t;
                    frac_reg <= {frac_reg[14:0], 1'b0};
                end
                it_reg <= it_reg + 1'b1;
            end
            B_MULK:
            begin
                logic signed [7:0]  expo;
                logic signed [23:0] l2;
                expo  = $signed({2'b00, e_reg}) + $signed({{(7 - SH_W){1'b0}}, s_reg, 1'b0})
                        - LOG_BIAS;
                l2    = $signed({expo, frac_reg});
                p_reg <= l2 * DB_K_Q16;
            end
            B_ROUND:
            begin
                logic [49:0]        mag;
                logic [50:0]        rnd;
                logic signed [19:0] rs;
                mag = p_reg[49] ? 50'(-p_reg) : 50'(p_reg);
                rnd = {1'b0, mag} + 51'(64'd2147483648);
                rs  = p_reg[49] ? -$signed({1'b0, rnd[50:32]}) : $signed({1'b0, rnd[50:32]});
                if (rs < 20'(DB_MIN))
                    level_reg <= DB_MIN;
                else if (rs > 20'(DB_MAX))
                    level_reg <= DB_MAX;
                else
                    level_reg <= rs[DB_W-1:0];
            end
            default:
            begin
            end
        endcase

        if (res_load)
        begin
            res_reg.frame_number <= fnum_reg;
            res_reg.bin          <= BIN_W'(k_reg);
            res_reg.level_db     <= level_reg;
            res_reg.last_bin     <= k_last;
        end
    end

endmodule

FILE: rtl/core/stft_power_spectrum_db_unit.sv
// Short-time spectrum of a 14-bit sample stream, in dB x 128.
// Input channel: push an item {sample, block_start} while full is low; each
// beat is one sample. block_start restarts framing and frame numbering.
// Result channel: while empty is low, result holds {frame_number, bin,
// level_db, last_bin}; pop takes the beat. Each completed frame yields 33
// beats, bins 0 to 32, last_bin set on bin 32.
// Config: overlap_we writes overlap_data into the overlap register at once;
// write it only while no frame is in flight. hop = 64 - overlap.
// Timing: a sample that completes no frame passes through the two-entry
// command queue and reaches the history in the cycle after it is accepted
// when the back end is idle. A frame costs a dispatch step and a window pass
// over the history, then per bin a 64-step multiply-accumulate over the
// scratch memory plus the magnitude and log unit, which shifts the magnitude
// (up to 21 times) and normalizes it (up to 62 steps); a zero magnitude
// skips normalize and log. Samples keep queueing (two deep) while a frame
// is in work; full rises after that.
// Reset: overlap is 32, history reads as zeros, framing starts as at a block.
// A stalled result holds on the port and halts the back end until popped.
module stft_power_spectrum_db_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  stftpsd_pkg::smp_in_t          item,
    output logic                          empty,
    input  logic                          pop,
    output stftpsd_pkg::res_t             result,
    input  logic                          overlap_we,
    input  logic [stftpsd_pkg::OVL_W-1:0] overlap_data
);
    import stftpsd_pkg::*;

    cmd_t q_wdata;
    cmd_t q_rdata;
    logic q_wr;
    logic q_full;
    logic q_rd;
    logic q_empty;

    stftpsd_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .item         (item),
        .overlap_we   (overlap_we),
        .overlap_data (overlap_data),
        .cmd_push     (q_wr),
        .cmd          (q_wdata),
        .cmd_full     (q_full)
    );

    stftpsd_cmd_fifo u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (q_wr),
        .wdata (q_wdata),
        .full  (q_full),
        .rd    (q_rd),
        .rdata (q_rdata),
        .empty (q_empty)
    );

    stftpsd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_empty (q_empty),
        .cmd       (q_rdata),
        .cmd_pop   (q_rd),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

endmodule

FILE: rtl/core/stftpsd_checker.sv
module stftpsd_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              empty,
    input logic              pop,
    input stftpsd_pkg::res_t result
);
    import stftpsd_pkg::*;

    // hold a waiting beat until popped
    a_hold_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(result)))
        else $error("result beat changed while stalled");

    a_bin_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (result.bin <= BIN_W'(NBINS - 1)))
        else $error("bin out of range");

    a_last_bin: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (result.last_bin == (result.bin == BIN_W'(NBINS - 1))))
        else $error("last_bin does not match final bin");

    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (result.level_db >= DB_MIN && result.level_db <= DB_MAX))
        else $error("level out of range");

    // bins of a frame follow in order
    a_bin_order: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && pop && !result.last_bin) ##1 !empty
            |-> (result.bin == $past(result.bin) + 1'b1))
        else $error("bin sequence broken");

endmodule

bind stft_power_spectrum_db_unit stftpsd_checker u_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .empty  (empty),
    .pop    (pop),
    .result (result)
);

FILE: verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import stftpsd_pkg::*;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                push = 1'b0;
    logic                full;
    smp_in_t             item = '0;
    logic                empty;
    logic                pop = 1'b0;
    res_t                result;
    logic                overlap_we = 1'b0;
    logic [OVL_W-1:0]    overlap_data = '0;

    stft_power_spectrum_db_unit DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .item         (item),
        .empty        (empty),
        .pop          (pop),
        .result       (result),
        .overlap_we   (overlap_we),
        .overlap_data (overlap_data)
    );

    always #2 clk = ~clk;

    localparam longint unsigned ONE_Q30 = 64'd1073741824;

    smp_in_t        sample_q[$];
    res_t           spectrum_q[$];
    int             errors = 0;

    // spectrum predictor state
    int             hann_w[NPERSEG];
    int             cos_q15[NPERSEG];
    int             sin_q15[NPERSEG];
    int             history[NPERSEG];
    int             fill_count;
    int             hop_count;
    logic [15:0]    frame_cnt;
    int             ovl_setting;

    function automatic longint taylor_q30(longint unsigned x, bit want_sin);
        longint unsigned x2;
        longint unsigned term;
        longint unsigned d;
        longint          acc;
        x2   = (x * x) >> 30;
        term = want_sin ? x : ONE_Q30;
        acc  = longint'(term);
        for (int k = 1; k <= 7; k++)
        begin
            d    = want_sin ? (2 * k) * (2 * k + 1) : (2 * k - 1) * (2 * k);
            term = ((term * x2) >> 30) / d;
            if (k % 2 == 1)
                acc -= longint'(term);
            else
                acc += longint'(term);
        end
        return acc;
    endfunction

    function automatic longint cos_of_turn(longint unsigned p, longint unsigned q);
        longint unsigned ph;
        longint unsigned f;
        longint unsigned x;
        longint          r;
        ph = ((p % q) << 32) / q;
        f  = ph & (ONE_Q30 - 1);
        x  = (f * 64'd1686629713) >> 30;
        case ((ph >> 30) & 3)
            0: r = taylor_q30(x, 1'b0);
            1: r = -taylor_q30(x, 1'b1);
            2: r = -taylor_q30(x, 1'b0);
            default: r = taylor_q30(x, 1'b1);
        endcase
        if (r > longint'(ONE_Q30))
            r = longint'(ONE_Q30);
        if (r < -longint'(ONE_Q30))
            r = -longint'(ONE_Q30);
        return r;
    endfunction

    function automatic int round_q15(longint c30);
        longint unsigned u;
        u = longint'(c30 + longint'(ONE_Q30)) + 64'd16384;
        return int'(u >> 15) - 32768;
    endfunction

    function automatic int level_db_of(longint re, longint im);
        longint unsigned a;
        longint unsigned b;
        longint unsigned mx;
        longint unsigned sq;
        longint unsigned m;
        longint unsigned mag;
        longint          frac;
        longint          l;
        longint          p;
        longint          r;
        int              s;
        int              e;
        a  = re < 0 ? longint'(-re) : re;
        b  = im < 0 ? longint'(-im) : im;
        mx = a > b ? a : b;
        s  = 0;
        while ((mx >> s) >= 64'h8000_0000)
            s++;
        a  = a >> s;
        b  = b >> s;
        sq = a * a + b * b;
        if (sq == 0)
            return -30720;
        e = 0;
        while (e < 63 && (sq >> (e + 1)) != 0)
            e++;
        m    = e >= 30 ? sq >> (e - 30) : sq << (30 - e);
        frac = 0;
        for (int i = 0; i < 16; i++)
        begin
            m    = (m * m) >> 30;
            frac = frac << 1;
            if (m >= 64'h8000_0000)
            begin
                frac = frac | 1;
                m    = m >> 1;
            end
        end
        l   = longint'(e + 2 * s - 86) * 65536 + frac;
        p   = l * 64'sd25252226;
        mag = p < 0 ? longint'(-p) : p;
        r   = longint'((mag + 64'h8000_0000) >> 32);
        if (p < 0)
            r = -r;
        if (r < -30720)
            r = -30720;
        if (r > 4096)
            r = 4096;
        return int'(r);
    endfunction

    task automatic predict_spectrum(smp_in_t s);
        longint win_smp[NPERSEG];
        longint re;
        longint im;
        int     hop;
        bit     frame_done;
        res_t   r;
        hop        = ovl_setting >= NPERSEG ? 1 : NPERSEG - ovl_setting;
        frame_done = 1'b0;
        if (s.block_start)
        begin
            fill_count = 0;
            hop_count  = 0;
            frame_cnt  = '0;
        end
        for (int n = 0; n < NPERSEG - 1; n++)
            history[n] = history[n + 1];
        history[NPERSEG - 1] = s.sample;
        if (fill_count < NPERSEG)
        begin
            fill_count++;
            if (fill_count == NPERSEG)
            begin
                frame_done = 1'b1;
                hop_count  = 0;
            end
        end
        else
        begin
            hop_count++;
            if (hop_count >= hop)
            begin
                frame_done = 1'b1;
                hop_count  = 0;
            end
        end
        if (!frame_done)
            return;
        for (int n = 0; n < NPERSEG; n++)
            win_smp[n] = longint'(history[n]) * hann_w[n];
        for (int k = 0; k < NBINS; k++)
        begin
            re = 0;
            im = 0;
            for (int n = 0; n < NPERSEG; n++)
            begin
                re += win_smp[n] * cos_q15[(k * n) % NPERSEG];
                im += win_smp[n] * sin_q15[(k * n) % NPERSEG];
            end
            r.frame_number = frame_cnt;
            r.bin          = k[BIN_W-1:0];
            r.level_db     = 16'(level_db_of(re, im));
            r.last_bin     = (k == NBINS - 1);
            spectrum_q.push_back(r);
        end
        frame_cnt = frame_cnt + 16'd1;
    endtask

    // sender: bursts with random gaps
    int burst_left = 4;
    int gap_left   = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push <= 1'b0;
        end
        else
        begin
            if (push && !full)
                predict_spectrum(item);
            if (!(push && full))
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    push <= 1'b0;
                end
                else if (sample_q.size() > 0)
                begin
                    item <= sample_q.pop_front();
                    push <= 1'b1;
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
                    end
                end
                else
                    push <= 1'b0;
            end
        end
    end

    // receiver: own stall pattern plus one long hold-off
    int  beats_seen = 0;
    int  hold_left  = 0;
    bit  held_once  = 1'b0;
    int  stall_mode = 0;
    int  mode_timer = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pop <= 1'b0;
        end
        else
        begin
            if (pop && !empty)
            begin
                beats_seen++;
                if (spectrum_q.size() == 0)
                begin
                    $error("unexpected result beat: frame %0d bin %0d",
                           result.frame_number, result.bin);
                    errors++;
                end
                else
                begin
                    res_t exp_r;
                    exp_r = spectrum_q.pop_front();
                    if (result.frame_number !== exp_r.frame_number)
                    begin
                        $error("frame_number: expected %0d, actual %0d",
                               exp_r.frame_number, result.frame_number);
                        errors++;
                    end
                    if (result.bin !== exp_r.bin)
                    begin
                        $error("bin: expected %0d, actual %0d", exp_r.bin, result.bin);
                        errors++;
                    end
                    if (result.level_db !== exp_r.level_db)
                    begin
                        $error("level_db: expected %0d, actual %0d",
                               exp_r.level_db, result.level_db);
                        errors++;
                    end
                    if (result.last_bin !== exp_r.last_bin)
                    begin
                        $error("last_bin: expected %0d, actual %0d",
                               exp_r.last_bin, result.last_bin);
                        errors++;
                    end
                end
            end
            if (!held_once && beats_seen >= 50)
            begin
                held_once = 1'b1;
                hold_left = 4000;
            end
            mode_timer++;
            if (mode_timer >= 300)
            begin
                mode_timer = 0;
                stall_mode = $urandom_range(0, 2);
            end
            if (hold_left > 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else if (stall_mode == 0)
                pop <= 1'b1;
            else if (stall_mode == 1)
                pop <= ($urandom_range(0, 1) == 0);
            else
                pop <= ($urandom_range(0, 4) == 0);
        end
    end

    task automatic wait_drained();
        do
            @(posedge clk);
        while (sample_q.size() != 0 || push || spectrum_q.size() != 0);
        // a sample that closes no frame may still be on its way to the history
        repeat (20) @(posedge clk);
    endtask

    task automatic write_overlap(int v);
        @(posedge clk);
        overlap_we   <= 1'b1;
        overlap_data <= v[OVL_W-1:0];
        ovl_setting  = v;
        @(posedge clk);
        overlap_we <= 1'b0;
    endtask

    function automatic smp_in_t rand_sample(bit may_start);
        smp_in_t s;
        s.sample      = 14'($urandom_range(0, 16383));
        s.block_start = may_start && ($urandom_range(0, 59) == 0);
        return s;
    endfunction

    initial
    begin
        smp_in_t s;
        int      ovl;
        int      hop;
        int      count;
        int      ovl_list[6];
        for (int i = 0; i < NPERSEG; i++)
        begin
            hann_w[i]  = int'((ONE_Q30 - cos_of_turn(i, NPERSEG - 1)) >> 16);
            if (hann_w[i] > 32767)
                hann_w[i] = 32767;
            cos_q15[i] = round_q15(cos_of_turn(i, NPERSEG));
            sin_q15[i] = round_q15(cos_of_turn(4 * i + 3 * NPERSEG, 4 * NPERSEG));
            history[i] = 0;
        end
        fill_count  = 0;
        hop_count   = 0;
        frame_cnt   = '0;
        ovl_setting = 32;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        write_overlap(32);

        // silence before any block start: zero magnitude on every bin
        for (int i = 0; i < NPERSEG; i++)
        begin
            s.sample      = '0;
            s.block_start = 1'b0;
            sample_q.push_back(s);
        end
        // full-scale Nyquist tone, then a DC run at the extremes
        for (int i = 0; i < NPERSEG + 32; i++)
        begin
            s.sample      = (i % 2 == 0) ? 14'sd8191 : -14'sd8192;
            s.block_start = (i == 0);
            if (i >= NPERSEG)
                s.sample = (i < NPERSEG + 16) ? 14'sd8191 : -14'sd8192;
            sample_q.push_back(s);
        end
        wait_drained();

        ovl_list = '{0, 63, 1, 50, 0, 0};
        ovl_list[4] = $urandom_range(0, 63);
        ovl_list[5] = $urandom_range(0, 63);
        for (int ph = 0; ph < 6; ph++)
        begin
            ovl = ovl_list[ph];
            write_overlap(ovl);
            hop   = NPERSEG - ovl;
            count = hop >= 32 ? 36 : (hop >= 8 ? 28 : 10);
            for (int i = 0; i < count; i++)
                sample_q.push_back(rand_sample(1'b1));
            wait_drained();
        end

        repeat (200) @(posedge clk);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        #50ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/stftpsd_pkg.sv
rtl/core/stftpsd_cmd_fifo.sv
rtl/core/stftpsd_front.sv
rtl/core/stftpsd_back.sv
rtl/core/stft_power_spectrum_db_unit.sv
rtl/core/stftpsd_checker.sv
verif/testbench.sv
